>>> src/circle_raster_canvas_macros.svh
// Assertion macros for the circle raster canvas.
`ifndef CIRCLE_RASTER_CANVAS_MACROS_SVH
`define CIRCLE_RASTER_CANVAS_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/crc_pkg.sv
// Package with constants, codes and types of the circle raster canvas.
package crc_pkg;

  localparam int MAX_SIDE      = 256;
  localparam int FRACTION_BITS = 8;
  localparam int COORD_W       = 19;
  localparam int CFG_W         = 9;
  localparam int PIX_W         = 8;
  localparam int RD_W          = 8;
  localparam int SIDE_W        = $clog2(MAX_SIDE);
  localparam int SIZE_W        = SIDE_W + 1;
  localparam int ADDR_W        = 2 * SIDE_W;
  localparam int DEPTH         = MAX_SIDE * MAX_SIDE;
  localparam int DX_W          = ((COORD_W > SIDE_W + FRACTION_BITS) ?
                                  COORD_W : SIDE_W + FRACTION_BITS) + 2;
  localparam int SQ_W          = 2 * DX_W;
  localparam longint ONE_L     = 64'sd1 <<< FRACTION_BITS;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_RADIUS = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE    = 2'd2;
  localparam logic [1:0] STAT_PENDING    = 2'd3;

  localparam logic [1:0] REG_WIDTH      = 2'd0;
  localparam logic [1:0] REG_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_BACKGROUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_READ,
    S_OUT
  } state_t;

  function automatic logic [SIZE_W-1:0] side_in_use(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] s;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      s = SIZE_W'(MAX_SIDE);
    end else begin
      s = SIZE_W'(v);
    end
    return s;
  endfunction

endpackage

>>> src/circle_raster_canvas.sv
// Circle raster canvas: a byte canvas of up to 256 by 256 pixels held in one
// single-port-write, registered-read memory. A clear writes one pixel per cycle
// over the canvas in use; a draw first forms the squared centre offsets and
// radii in a setup state, then sweeps the same pixels at one pixel per cycle,
// writing memory only where a pixel hits the circle or ring. Squared distances
// are stepped by additions along each row and column. A read goes through the
// registered memory output; a draw or read refused by a pending error, a bad
// radius or an address outside the canvas answers without a memory access.
// A new item is taken while the previous result still waits at the output.
`include "circle_raster_canvas_macros.svh"

module circle_raster_canvas (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_kind,
  input  logic                                 in_filled,
  input  logic signed [crc_pkg::COORD_W-1:0]   in_centre_x,
  input  logic signed [crc_pkg::COORD_W-1:0]   in_centre_y,
  input  logic signed [crc_pkg::COORD_W-1:0]   in_radius,
  input  logic [crc_pkg::PIX_W-1:0]            in_paint_byte,
  input  logic [crc_pkg::RD_W-1:0]             in_read_column,
  input  logic [crc_pkg::RD_W-1:0]             in_read_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [crc_pkg::PIX_W-1:0]            out_pixel_value,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [crc_pkg::CFG_W-1:0]            cfg_wdata
);
  import crc_pkg::*;

  localparam logic signed [DX_W-1:0]    DX_ONE    = DX_W'(ONE_L);
  localparam logic signed [SQ_W-1:0]    SQ_ONE    = SQ_W'(ONE_L * ONE_L);
  localparam logic signed [COORD_W:0]   INNER_ONE = (COORD_W + 1)'(ONE_L);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic [PIX_W-1:0] cfg_bg_r;
  logic             error_seen_r;

  logic                       clear_mode_r, fill_r, has_inner_r;
  logic [PIX_W-1:0]           paint_r;
  logic signed [COORD_W-1:0]  cx_r, cy_r, rad_r;
  logic signed [SQ_W-1:0]     cx2_r, r2_r, in2_r, dx2_r, dy2_r;
  logic signed [DX_W-1:0]     dx_r, dy_r;
  logic [SIDE_W-1:0]          x_r, y_r;
  logic [ADDR_W-1:0]          rd_addr_r;
  logic [PIX_W-1:0]           mem_q_r;
  logic [1:0]                 res_status_r;
  logic                       res_from_mem_r;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [PIX_W-1:0]           out_pixel_r;

  logic [PIX_W-1:0] canvas_mem [DEPTH];

  logic [SIZE_W-1:0]            w_use, h_use;
  logic [SIDE_W-1:0]            w_m1, h_m1;
  logic                         acc, out_free, err_now, bad_radius, read_outside;
  logic                         draw_ok, read_ok;
  logic [1:0]                   imm_status;
  logic signed [2*COORD_W-1:0]  cx_sq, cy_sq, r_sq;
  logic signed [COORD_W:0]      inner;
  logic signed [2*COORD_W+1:0]  inner_sq;
  logic signed [SQ_W-1:0]       d2, dx_step, dy_step;
  logic                         hit, last_col, last_row, mem_we, load_out;

  assign w_use    = side_in_use(cfg_width_r);
  assign h_use    = side_in_use(cfg_height_r);
  assign w_m1     = SIDE_W'(w_use - SIZE_W'(1));
  assign h_m1     = SIDE_W'(h_use - SIZE_W'(1));
  assign out_free = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign err_now      = error_seen_r;
  assign bad_radius   = (in_radius <= 0);
  assign read_outside = (int'(in_read_column) >= int'(w_use)) ||
                        (int'(in_read_row) >= int'(h_use));
  assign draw_ok      = (in_kind == KIND_DRAW) && !err_now && !bad_radius;
  assign read_ok      = (in_kind == KIND_READ) && !err_now && !read_outside;

  always_comb begin
    case (in_kind)
      KIND_DRAW: imm_status = err_now ? STAT_PENDING : STAT_BAD_RADIUS;
      KIND_READ: imm_status = err_now ? STAT_PENDING : STAT_OUTSIDE;
      default:   imm_status = STAT_OK;
    endcase
  end

  assign cx_sq    = cx_r * cx_r;
  assign cy_sq    = cy_r * cy_r;
  assign r_sq     = rad_r * rad_r;
  assign inner    = $signed({rad_r[COORD_W-1], rad_r}) - INNER_ONE;
  assign inner_sq = inner * inner;

  assign d2      = dx2_r + dy2_r;
  assign dx_step = (SQ_W'(dx_r) <<< (FRACTION_BITS + 1)) + SQ_ONE;
  assign dy_step = (SQ_W'(dy_r) <<< (FRACTION_BITS + 1)) + SQ_ONE;
  assign hit     = (d2 <= r2_r) && !(!fill_r && has_inner_r && (d2 <= in2_r));
  assign last_col = (x_r == w_m1);
  assign last_row = (y_r == h_m1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_kind == KIND_CLEAR) begin
            state_nxt = S_SWEEP;
          end else if (draw_ok) begin
            state_nxt = S_SETUP;
          end else if (read_ok) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SETUP: state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (last_col && last_row) begin
          state_nxt = S_OUT;
        end
      end
      S_READ: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    mem_we   = (state_r == S_SWEEP) && (clear_mode_r || hit);
    load_out = (state_r == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_width_r  <= CFG_W'(1);
      cfg_height_r <= CFG_W'(1);
      cfg_bg_r     <= PIX_W'(32);
      error_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:      cfg_width_r  <= cfg_wdata;
          REG_HEIGHT:     cfg_height_r <= cfg_wdata;
          REG_BACKGROUND: cfg_bg_r     <= cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end
      if (acc && in_kind == KIND_CLEAR) begin
        error_seen_r <= 1'b0;
      end else if (acc && in_kind == KIND_DRAW && !err_now && bad_radius) begin
        error_seen_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          clear_mode_r   <= (in_kind == KIND_CLEAR);
          paint_r        <= (in_kind == KIND_CLEAR) ? cfg_bg_r : in_paint_byte;
          fill_r         <= in_filled;
          cx_r           <= in_centre_x;
          cy_r           <= in_centre_y;
          rad_r          <= in_radius;
          x_r            <= '0;
          y_r            <= '0;
          rd_addr_r      <= {SIDE_W'(in_read_row), SIDE_W'(in_read_column)};
          res_status_r   <= (in_kind == KIND_CLEAR || draw_ok || read_ok) ?
                            STAT_OK : imm_status;
          res_from_mem_r <= read_ok;
        end
      end
      S_SETUP: begin
        dx_r        <= -DX_W'(cx_r);
        dy_r        <= -DX_W'(cy_r);
        cx2_r       <= SQ_W'(cx_sq);
        dx2_r       <= SQ_W'(cx_sq);
        dy2_r       <= SQ_W'(cy_sq);
        r2_r        <= SQ_W'(r_sq);
        in2_r       <= SQ_W'(inner_sq);
        has_inner_r <= (inner >= 0);
      end
      S_SWEEP: begin
        if (last_col) begin
          x_r   <= '0;
          dx_r  <= -DX_W'(cx_r);
          dx2_r <= cx2_r;
          if (!last_row) begin
            y_r   <= y_r + SIDE_W'(1);
            dy_r  <= dy_r + DX_ONE;
            dy2_r <= dy2_r + dy_step;
          end
        end else begin
          x_r   <= x_r + SIDE_W'(1);
          dx_r  <= dx_r + DX_ONE;
          dx2_r <= dx2_r + dx_step;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_status_r <= res_status_r;
      out_pixel_r  <= res_from_mem_r ? mem_q_r : '0;
    end
  end

  // Writes happen only in a sweep and reads only after it, so no forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      canvas_mem[{y_r, x_r}] <= paint_r;
    end
    mem_q_r <= canvas_mem[rd_addr_r];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pixel_value = out_pixel_r;

  `CRC_ASSERT_SAME(a_we_in_sweep, mem_we, state_r == S_SWEEP, "canvas write outside sweep")
  `CRC_ASSERT_SAME(a_sweep_bounds, state_r == S_SWEEP, (x_r <= w_m1) && (y_r <= h_m1), "sweep out of canvas")
  `CRC_ASSERT_NEXT(a_out_from_out, !out_valid_r && state_r != S_OUT, !out_valid_r, "result without completion")
  `CRC_ASSERT_NEXT(a_bad_radius_err, acc && in_kind == KIND_DRAW && !error_seen_r && in_radius <= 0, error_seen_r, "bad radius not flagged")
  `CRC_ASSERT_NEXT(a_clear_err, acc && in_kind == KIND_CLEAR, !error_seen_r, "clear kept error")

endmodule

>>> bench/canvas_checker.sv
// Checker: predicts each circle raster canvas result and compares it on every output transfer.
module canvas_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic                               in_filled,
  input  logic signed [crc_pkg::COORD_W-1:0] in_centre_x,
  input  logic signed [crc_pkg::COORD_W-1:0] in_centre_y,
  input  logic signed [crc_pkg::COORD_W-1:0] in_radius,
  input  logic [crc_pkg::PIX_W-1:0]          in_paint_byte,
  input  logic [crc_pkg::RD_W-1:0]           in_read_column,
  input  logic [crc_pkg::RD_W-1:0]           in_read_row,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         out_status,
  input  logic [crc_pkg::PIX_W-1:0]          out_pixel_value,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [crc_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  import crc_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [PIX_W-1:0] pixel;
  } pixel_answer_t;

  logic [PIX_W-1:0] canvas [DEPTH];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] background;
  logic             faulted;
  int               fails = 0;
  pixel_answer_t    answers_q [$];

  function automatic int clamp_side(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_SIDE)) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic pixel_answer_t rasterize(
    logic [1:0] kind, logic filled,
    logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
    logic signed [COORD_W-1:0] rad, logic [PIX_W-1:0] paint,
    logic [RD_W-1:0] col, logic [RD_W-1:0] row);
    pixel_answer_t a;
    int            w;
    int            h;
    longint        one;
    longint        r2;
    longint        inner;
    longint        inner2;
    longint        dx;
    longint        dy;
    longint        d2;
    logic          ring;
    a   = '0;
    w   = clamp_side(width_reg);
    h   = clamp_side(height_reg);
    one = longint'(1) << FRACTION_BITS;
    case (kind)
      KIND_CLEAR: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            canvas[y * MAX_SIDE + x] = background;
        faulted = 1'b0;
      end
      KIND_DRAW: begin
        if (faulted) begin
          a.status = STAT_PENDING;
        end else if (rad <= 0) begin
          faulted  = 1'b1;
          a.status = STAT_BAD_RADIUS;
        end else begin
          r2     = longint'(rad) * longint'(rad);
          inner  = longint'(rad) - one;
          inner2 = inner * inner;
          ring   = !filled && inner >= 0;
          for (int y = 0; y < h; y++) begin
            dy = longint'(y) * one - longint'(cy);
            for (int x = 0; x < w; x++) begin
              dx = longint'(x) * one - longint'(cx);
              d2 = dx * dx + dy * dy;
              if (d2 <= r2 && !(ring && d2 <= inner2))
                canvas[y * MAX_SIDE + x] = paint;
            end
          end
        end
      end
      KIND_READ: begin
        if (faulted) begin
          a.status = STAT_PENDING;
        end else if (col >= w || row >= h) begin
          a.status = STAT_OUTSIDE;
        end else begin
          a.pixel = canvas[int'(row) * MAX_SIDE + int'(col)];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string field, logic [PIX_W-1:0] expected, logic [PIX_W-1:0] actual);
    fails++;
    if (fails <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
  endtask

  always @(posedge clk) begin
    pixel_answer_t want;
    if (!rst_n) begin
      width_reg  = CFG_W'(1);
      height_reg = CFG_W'(1);
      background = PIX_W'(32);
      faulted    = 1'b0;
      answers_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:      width_reg  = cfg_wdata;
          REG_HEIGHT:     height_reg = cfg_wdata;
          REG_BACKGROUND: background = cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        answers_q.push_back(rasterize(in_kind, in_filled, in_centre_x, in_centre_y,
                                      in_radius, in_paint_byte, in_read_column,
                                      in_read_row));
      if (out_valid && out_ready) begin
        if (answers_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result transfer with none expected, status %0d, pixel %0d",
                     $time, out_status, out_pixel_value);
        end else begin
          want = answers_q.pop_front();
          if (out_status !== want.status)
            report("status", PIX_W'(want.status), PIX_W'(out_status));
          if (out_pixel_value !== want.pixel)
            report("pixel_value", want.pixel, out_pixel_value);
        end
      end
    end
    fail_count <= fails;
    pending    <= answers_q.size();
  end

endmodule

>>> bench/tb.sv
// Testbench top: drives circle raster canvas stimulus and configuration, gives the verdict.
module tb;
  import crc_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 3_000_000;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_kind         = KIND_CLEAR;
  logic                      in_filled       = 1'b0;
  logic signed [COORD_W-1:0] in_centre_x     = '0;
  logic signed [COORD_W-1:0] in_centre_y     = '0;
  logic signed [COORD_W-1:0] in_radius       = '0;
  logic [PIX_W-1:0]          in_paint_byte   = '0;
  logic [RD_W-1:0]           in_read_column  = '0;
  logic [RD_W-1:0]           in_read_row     = '0;
  logic                      out_valid;
  logic                      out_ready       = 1'b0;
  logic [1:0]                out_status;
  logic [PIX_W-1:0]          out_pixel_value;
  logic                      cfg_we          = 1'b0;
  logic [1:0]                cfg_index       = REG_WIDTH;
  logic [CFG_W-1:0]          cfg_wdata       = '0;
  int                        fail_count;
  int                        pending;
  int                        cycles          = 0;
  int                        hold_cycles     = 0;
  bit                        steady          = 1'b0;
  int                        side_w          = 1;
  int                        side_h          = 1;

  circle_raster_canvas DUT (.*);

  canvas_checker watch (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] fx(int whole);
    return COORD_W'(whole * (1 << FRACTION_BITS));
  endfunction

  // stall the result side in random bursts
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0)
        hold_cycles = gap_len();
    end
  end

  task automatic send(logic [1:0] kind, logic filled,
                      logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                      logic signed [COORD_W-1:0] rad, logic [PIX_W-1:0] paint,
                      logic [RD_W-1:0] col, logic [RD_W-1:0] row);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_filled      <= filled;
    in_centre_x    <= cx;
    in_centre_y    <= cy;
    in_radius      <= rad;
    in_paint_byte  <= paint;
    in_read_column <= col;
    in_read_row    <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic clear_canvas();
    send(KIND_CLEAR, 1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
         COORD_W'($urandom), PIX_W'($urandom), RD_W'($urandom), RD_W'($urandom));
  endtask

  task automatic draw_circle(logic filled, logic signed [COORD_W-1:0] cx,
                             logic signed [COORD_W-1:0] cy,
                             logic signed [COORD_W-1:0] rad, logic [PIX_W-1:0] paint);
    send(KIND_DRAW, filled, cx, cy, rad, paint, RD_W'($urandom), RD_W'($urandom));
  endtask

  task automatic read_pixel(logic [RD_W-1:0] col, logic [RD_W-1:0] row);
    send(KIND_READ, 1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
         COORD_W'($urandom), PIX_W'($urandom), col, row);
  endtask

  // hold input until every result has been transferred
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_canvas(int w, int h, int bg);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= REG_BACKGROUND;
    cfg_wdata <= CFG_W'(bg);
    @(posedge clk);
    cfg_we <= 1'b0;
    side_w = (w == 0) ? 1 : ((w > MAX_SIDE) ? MAX_SIDE : w);
    side_h = (h == 0) ? 1 : ((h > MAX_SIDE) ? MAX_SIDE : h);
  endtask

  task automatic random_phase(int count);
    int pick;
    int big;
    int cx;
    int cy;
    int rad;
    big = (side_w > side_h) ? side_w : side_h;
    clear_canvas();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) settle();
      pick = $urandom_range(0, 99);
      cx   = int'($urandom_range(0, (side_w + 4) << FRACTION_BITS)) - (2 << FRACTION_BITS);
      cy   = int'($urandom_range(0, (side_h + 4) << FRACTION_BITS)) - (2 << FRACTION_BITS);
      rad  = int'($urandom_range(1, ((big / 2) + 3) << FRACTION_BITS));
      if (pick < 40) begin
        draw_circle(1'($urandom_range(0, 1)), COORD_W'(cx), COORD_W'(cy), COORD_W'(rad),
                    PIX_W'($urandom));
      end else if (pick < 70) begin
        if ($urandom_range(0, 6) == 0)
          read_pixel(RD_W'($urandom), RD_W'($urandom));
        else
          read_pixel(RD_W'($urandom_range(0, side_w - 1)),
                     RD_W'($urandom_range(0, side_h - 1)));
      end else if (pick < 78) begin
        clear_canvas();
      end else if (pick < 82) begin
        rad = -int'($urandom_range(0, 1 << (COORD_W - 1)));
        draw_circle(1'($urandom_range(0, 1)), COORD_W'(cx), COORD_W'(cy), COORD_W'(rad),
                    PIX_W'($urandom));
      end else begin
        send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), COORD_W'($urandom),
             COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom),
             RD_W'($urandom), RD_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    clear_canvas();
    read_pixel(0, 0);
    read_pixel(1, 0);
    send(KIND_NONE, 1'b1, fx(-1), fx(-1), fx(-1), 8'hFF, 8'hFF, 8'hFF);
    draw_circle(1'b1, fx(0), fx(0), fx(1), 8'hFF);
    read_pixel(0, 0);

    set_canvas(8, 8, 8'hFF);
    clear_canvas();
    set_canvas(4, 4, 8'h00);
    clear_canvas();
    draw_circle(1'b1, fx(2), fx(2), fx(10), 8'h11);
    draw_circle(1'b0, fx(1), fx(1), COORD_W'(1 << (FRACTION_BITS - 1)), 8'h22);
    draw_circle(1'b0, fx(0), fx(0), fx(2), 8'h33);
    read_pixel(1, 1);
    read_pixel(1, 0);
    read_pixel(3, 3);

    set_canvas(8, 8, 8'h5A);
    read_pixel(6, 6);
    read_pixel(7, 7);
    draw_circle(1'b1, fx(3), fx(3), '0, 8'h44);
    draw_circle(1'b1, fx(3), fx(3), fx(2), 8'h44);
    read_pixel(3, 3);
    clear_canvas();
    draw_circle(1'b1, 19'sh40000, 19'sh40000, 19'sh40000, 8'h44);
    clear_canvas();
    draw_circle(1'b0, 19'sh3FFFF, 19'sh40000, 19'sh3FFFF, 8'h00);
    draw_circle(1'b1, fx(-1), fx(-1), 19'sh3FFFF, 8'h00);
    read_pixel(7, 7);

    set_canvas($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 255));
    random_phase(12);
    set_canvas(256, 0, $urandom_range(0, 255));
    random_phase(10);
    set_canvas(0, 300, $urandom_range(0, 255));
    random_phase(10);
    steady <= 1'b1;
    set_canvas($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 255));
    random_phase(15);
    steady <= 1'b0;
    set_canvas($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 255));
    random_phase(18);

    set_canvas(511, 511, $urandom_range(0, 255));
    clear_canvas();
    draw_circle(1'($urandom_range(0, 1)), fx($urandom_range(0, 255)),
                fx($urandom_range(0, 255)), fx($urandom_range(20, 100)), PIX_W'($urandom));
    read_pixel(8'd255, 8'd255);
    read_pixel(0, 0);
    read_pixel(RD_W'($urandom), RD_W'($urandom));

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
